@@ rtl/dtmoa_pkg.sv @@
package dtmoa_pkg;

    // Calendar and clock limits
    localparam int MIN_PER_HOUR  = 60;
    localparam int MIN_PER_DAY   = 24 * MIN_PER_HOUR;
    localparam int MAX_OFFSET    = MIN_PER_DAY - 1;
    localparam int MAX_YEAR      = 9999;
    localparam int LAST_HOUR     = 23;
    localparam int LAST_MINUTE   = MIN_PER_HOUR - 1;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    // One request: the timestamp and the offset to add
    typedef struct packed {
        logic [13:0]        year_in;
        logic [3:0]         month_in;
        logic [4:0]         day_in;
        logic [4:0]         hour_in;
        logic [5:0]         minute_in;
        logic signed [11:0] offset_minutes;
    } t_dt_request;

    // One result: adjusted timestamp plus the valid flag
    typedef struct packed {
        logic [13:0] year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic [4:0]  hour_out;
        logic [5:0]  minute_out;
        logic        result_valid;
    } t_dt_result;

    // Days in month m (expects 1..12); leap selects 29 for February
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        case (m) inside
            MONTH_FEB:                               d = leap ? 5'd29 : 5'd28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: d = 5'd30;
            default:                                 d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

@@ rtl/date_time_minute_offset_adder.sv @@
// Channel   Direction  Handshake           Payload
// request   in         i_valid / o_ready   i_year_in .. i_offset_minutes
// result    out        o_valid / i_ready   o_year_out .. o_result_valid
//
// Two register stages: request register, then result register; one request
// is taken every cycle when the result side is ready.
// The date/time arithmetic between the stages is one pass of short logic.
// Reset (i_rst_n low, synchronous) clears both stage valid flags only.
// Each stage loads when empty or when the stage after it moves, so a stalled
// result holds while the request register can still fill behind it.
module date_time_minute_offset_adder
    import dtmoa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [13:0]        i_year_in,
    input  logic [3:0]         i_month_in,
    input  logic [4:0]         i_day_in,
    input  logic [4:0]         i_hour_in,
    input  logic [5:0]         i_minute_in,
    input  logic signed [11:0] i_offset_minutes,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [13:0]        o_year_out,
    output logic [3:0]         o_month_out,
    output logic [4:0]         o_day_out,
    output logic [4:0]         o_hour_out,
    output logic [5:0]         o_minute_out,
    output logic               o_result_valid
);

    logic        r_in_valid;
    t_dt_request r_req;
    logic        r_out_valid;
    t_dt_result  r_res;
    t_dt_result  n_res;
    logic        w_out_ready;

    assign w_out_ready = !r_out_valid || i_ready;
    assign o_ready     = !r_in_valid || w_out_ready;

    // Request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_req.year_in        <= i_year_in;
            r_req.month_in       <= i_month_in;
            r_req.day_in         <= i_day_in;
            r_req.hour_in        <= i_hour_in;
            r_req.minute_in      <= i_minute_in;
            r_req.offset_minutes <= i_offset_minutes;
        end
    end

    // Date/time arithmetic
    dtmoa_calc u_calc (
        .i_req (r_req),
        .o_res (n_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && w_out_ready) begin
            r_res <= n_res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_year_out     = r_res.year_out;
    assign o_month_out    = r_res.month_out;
    assign o_day_out      = r_res.day_out;
    assign o_hour_out     = r_res.hour_out;
    assign o_minute_out   = r_res.minute_out;
    assign o_result_valid = r_res.result_valid;

`ifndef NO_ASSERTIONS
    // A rejected result carries zeros in every field
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result_valid) |->
            (o_year_out == 14'd0 && o_month_out == 4'd0 && o_day_out == 5'd0 &&
             o_hour_out == 5'd0 && o_minute_out == 6'd0))
        else $error("rejected result has nonzero fields");

    // An accepted result lies within calendar and clock ranges
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_result_valid) |->
            (o_month_out >= MONTH_JAN && o_month_out <= MONTH_DEC &&
             o_day_out != 5'd0 && o_hour_out <= 5'(LAST_HOUR) &&
             o_minute_out <= 6'(LAST_MINUTE) && o_year_out <= 14'(MAX_YEAR)))
        else $error("accepted result out of range");

    // Both stages full and the output stalled: no new request is taken
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_ready) |-> !o_ready)
        else $error("request taken while pipeline full");

    // A taken request occupies the request register next cycle
    a_take_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_in_valid)
        else $error("taken request lost");
`endif

endmodule

@@ rtl/dtmoa_calc.sv @@
module dtmoa_calc
    import dtmoa_pkg::*;
(
    input  t_dt_request i_req,
    output t_dt_result  o_res
);

    // Leap year: y % 4 == 0 and (y % 100 != 0 or y % 16 == 0).
    // With y % 4 == 0, y % 100 == 0 reduces to (y >> 2) % 25 == 0,
    // done with a reciprocal multiply (exact for 12-bit quotients).
    logic [11:0] w_q;
    logic [22:0] w_q_prod;
    logic [7:0]  w_q25;
    logic [11:0] w_rem;
    logic        w_div4;
    logic        w_cent;
    logic        w_leap;

    assign w_q      = i_req.year_in[13:2];
    assign w_q_prod = 23'(w_q) * 23'd1311;
    assign w_q25    = w_q_prod[22:15];
    assign w_rem    = w_q - (12'({w_q25, 4'b0}) + 12'({w_q25, 3'b0}) + 12'(w_q25));
    assign w_div4   = (i_req.year_in[1:0] == 2'b00);
    assign w_cent   = (w_rem == 12'd0);
    assign w_leap   = w_div4 && (!w_cent || (i_req.year_in[3:0] == 4'd0));

    // Input range checks
    logic [4:0] w_mdays;
    logic [4:0] w_prev_mdays;
    logic       w_month_ok;
    logic       w_day_ok;
    logic       w_time_ok;
    logic       w_off_ok;
    logic       w_in_ok;

    assign w_mdays      = month_days(i_req.month_in, w_leap);
    assign w_prev_mdays = month_days(i_req.month_in - 4'd1, w_leap);
    assign w_month_ok   = (i_req.month_in >= MONTH_JAN) && (i_req.month_in <= MONTH_DEC);
    assign w_day_ok     = (i_req.day_in != 5'd0) && (i_req.day_in <= w_mdays);
    assign w_time_ok    = (i_req.hour_in <= 5'(LAST_HOUR)) &&
                          (i_req.minute_in <= 6'(LAST_MINUTE));
    assign w_off_ok     = (i_req.offset_minutes >= -12'sd1439) &&
                          (i_req.offset_minutes <= 12'sd1439);
    assign w_in_ok      = w_month_ok && w_day_ok && w_time_ok && w_off_ok;

    // Minute of day plus offset, then fold back into one day
    logic [10:0]        w_hm;
    logic signed [12:0] w_total;
    logic               w_under;
    logic               w_over;
    logic [10:0]        w_tod;

    assign w_hm    = 11'({i_req.hour_in, 6'b0}) - 11'({i_req.hour_in, 2'b0});
    assign w_total = $signed({2'b00, w_hm}) + $signed({7'b0, i_req.minute_in})
                   + $signed({i_req.offset_minutes[11], i_req.offset_minutes});
    assign w_under = w_total[12];
    assign w_over  = !w_under && (w_total >= 13'(MIN_PER_DAY));

    always_comb begin
        if (w_under) begin
            w_tod = 11'(w_total + 13'(MIN_PER_DAY));
        end else if (w_over) begin
            w_tod = 11'(w_total - 13'(MIN_PER_DAY));
        end else begin
            w_tod = 11'(w_total);
        end
    end

    // Split minute of day: hour by reciprocal of 60, minute as remainder
    logic [21:0] w_h_prod;
    logic [4:0]  w_hour;
    logic [5:0]  w_minute;

    assign w_h_prod = 22'(w_tod) * 22'd2185;
    assign w_hour   = w_h_prod[21:17];
    assign w_minute = 6'(w_tod - (11'({w_hour, 6'b0}) - 11'({w_hour, 2'b0})));

    // Day, month and year carry in either direction
    logic [14:0] w_year;
    logic [3:0]  w_month;
    logic [4:0]  w_day;
    logic        w_year_low;

    always_comb begin
        w_year     = {1'b0, i_req.year_in};
        w_month    = i_req.month_in;
        w_day      = i_req.day_in;
        w_year_low = 1'b0;
        if (w_under) begin
            if (i_req.day_in == 5'd1) begin
                if (i_req.month_in == MONTH_JAN) begin
                    w_month    = MONTH_DEC;
                    w_day      = 5'd31;
                    w_year_low = (i_req.year_in == 14'd0);
                    w_year     = {1'b0, i_req.year_in} - 15'd1;
                end else begin
                    w_month = i_req.month_in - 4'd1;
                    w_day   = w_prev_mdays;
                end
            end else begin
                w_day = i_req.day_in - 5'd1;
            end
        end else if (w_over) begin
            if (i_req.day_in == w_mdays) begin
                w_day = 5'd1;
                if (i_req.month_in == MONTH_DEC) begin
                    w_month = MONTH_JAN;
                    w_year  = {1'b0, i_req.year_in} + 15'd1;
                end else begin
                    w_month = i_req.month_in + 4'd1;
                end
            end else begin
                w_day = i_req.day_in + 5'd1;
            end
        end
    end

    // Rejected results carry all-zero fields
    logic w_ok;

    assign w_ok = w_in_ok && !w_year_low && (w_year <= 15'(MAX_YEAR));

    always_comb begin
        o_res = '0;
        if (w_ok) begin
            o_res.year_out     = w_year[13:0];
            o_res.month_out    = w_month;
            o_res.day_out      = w_day;
            o_res.hour_out     = w_hour;
            o_res.minute_out   = w_minute;
            o_res.result_valid = 1'b1;
        end
    end

endmodule

@@ test/date_time_minute_offset_adder_tb.sv @@
`timescale 1ns / 100ps

module date_time_minute_offset_adder_tb;
    import dtmoa_pkg::*;

    localparam int RANDOM_STAMPS = 1750;
    localparam int CYCLE_LIMIT   = 100000;
    localparam int DRAIN_CYCLES  = 8;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [13:0]        i_year_in;
    logic [3:0]         i_month_in;
    logic [4:0]         i_day_in;
    logic [4:0]         i_hour_in;
    logic [5:0]         i_minute_in;
    logic signed [11:0] i_offset_minutes;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [13:0]        o_year_out;
    logic [3:0]         o_month_out;
    logic [4:0]         o_day_out;
    logic [4:0]         o_hour_out;
    logic [5:0]         o_minute_out;
    logic               o_result_valid;

    t_dt_request stamps_to_send[$];
    t_dt_result  expected_stamps[$];
    t_dt_request cur_req = '0;
    logic        req_taken = 1'b0;

    int n_total;
    int n_directed;
    int n_accepted;
    int n_shifted;
    int n_rejected;
    int n_errors;
    int n_cycles;

    date_time_minute_offset_adder dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_year_in        (i_year_in),
        .i_month_in       (i_month_in),
        .i_day_in         (i_day_in),
        .i_hour_in        (i_hour_in),
        .i_minute_in      (i_minute_in),
        .i_offset_minutes (i_offset_minutes),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_year_out       (o_year_out),
        .o_month_out      (o_month_out),
        .o_day_out        (o_day_out),
        .o_hour_out       (o_hour_out),
        .o_minute_out     (o_minute_out),
        .o_result_valid   (o_result_valid)
    );

    // Request payload comes straight from the request being offered
    assign i_year_in        = cur_req.year_in;
    assign i_month_in       = cur_req.month_in;
    assign i_day_in         = cur_req.day_in;
    assign i_hour_in        = cur_req.hour_in;
    assign i_minute_in      = cur_req.minute_in;
    assign i_offset_minutes = cur_req.offset_minutes;

    // Gregorian leap rule; year 0 counts as leap
    function automatic bit leap_year(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int month_len(input int y, input int m);
        case (m) inside
            MONTH_FEB: return leap_year(y) ? 29 : 28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 30;
            default: return 31;
        endcase
    endfunction

    // Expected result of shifting one timestamp by its minute offset
    function automatic t_dt_result shift_timestamp(input t_dt_request r);
        int y;
        int m;
        int d;
        int h;
        int mi;
        int off;
        int total;
        bit ok;
        t_dt_result res;
        y   = r.year_in;
        m   = r.month_in;
        d   = r.day_in;
        h   = r.hour_in;
        mi  = r.minute_in;
        off = int'($signed(r.offset_minutes));
        ok  = 1'b1;
        if (m < 1 || m > 12)
            ok = 1'b0;
        else if (d < 1 || d > month_len(y, m))
            ok = 1'b0;
        if (h > LAST_HOUR || mi > LAST_MINUTE)
            ok = 1'b0;
        if (off < -MAX_OFFSET || off > MAX_OFFSET)
            ok = 1'b0;
        if (ok) begin
            total = h * MIN_PER_HOUR + mi + off;
            if (total < 0) begin
                // back one day, possibly into the previous month / year
                total += MIN_PER_DAY;
                d--;
                if (d < 1) begin
                    m--;
                    if (m < 1) begin
                        m = 12;
                        y--;
                    end
                    d = (y >= 0) ? month_len(y, m) : 31;
                end
            end else if (total >= MIN_PER_DAY) begin
                // forward one day
                total -= MIN_PER_DAY;
                d++;
                if (d > month_len(y, m)) begin
                    d = 1;
                    m++;
                    if (m > 12) begin
                        m = 1;
                        y++;
                    end
                end
            end
            if (y < 0 || y > MAX_YEAR)
                ok = 1'b0;
            h  = total / MIN_PER_HOUR;
            mi = total % MIN_PER_HOUR;
        end
        res = '0;
        if (ok) begin
            res.year_out     = y[13:0];
            res.month_out    = m[3:0];
            res.day_out      = d[4:0];
            res.hour_out     = h[4:0];
            res.minute_out   = mi[5:0];
            res.result_valid = 1'b1;
        end
        return res;
    endfunction

    function automatic t_dt_request stamp(input int y, input int m, input int d,
                                          input int h, input int mi, input int off);
        t_dt_request r;
        r.year_in        = y[13:0];
        r.month_in       = m[3:0];
        r.day_in         = d[4:0];
        r.hour_in        = h[4:0];
        r.minute_in      = mi[5:0];
        r.offset_minutes = off[11:0];
        return r;
    endfunction

    // Random request: mostly well-formed, some with one bad field, some pure noise
    function automatic t_dt_request random_stamp();
        t_dt_request r;
        int y;
        int m;
        int d;
        int h;
        int mi;
        int off;
        int dim;
        int pick;
        pick = $urandom_range(99);
        if (pick < 15) begin
            r.year_in        = 14'($urandom);
            r.month_in       = 4'($urandom);
            r.day_in         = 5'($urandom);
            r.hour_in        = 5'($urandom);
            r.minute_in      = 6'($urandom);
            r.offset_minutes = 12'($urandom);
            return r;
        end
        // years near the leap-rule and range edges
        if ($urandom_range(4) == 0) begin
            case ($urandom_range(7))
                0: y = 0;
                1: y = 1;
                2: y = 4;
                3: y = 100;
                4: y = 400;
                5: y = 1900;
                6: y = 2000;
                default: y = MAX_YEAR;
            endcase
        end else begin
            y = $urandom_range(MAX_YEAR);
        end
        m   = $urandom_range(12, 1);
        dim = month_len(y, m);
        if ($urandom_range(9) < 4)
            d = $urandom_range(1) ? dim : 1;
        else
            d = $urandom_range(dim, 1);
        if ($urandom_range(9) < 3)
            h = $urandom_range(1) ? LAST_HOUR : 0;
        else
            h = $urandom_range(LAST_HOUR);
        if ($urandom_range(9) < 3)
            mi = $urandom_range(1) ? LAST_MINUTE : 0;
        else
            mi = $urandom_range(LAST_MINUTE);
        case ($urandom_range(11))
            0: off = MAX_OFFSET;
            1: off = -MAX_OFFSET;
            2: off = $urandom_range(1) ? 1 : -1;
            default: off = int'($urandom_range(2 * MAX_OFFSET)) - MAX_OFFSET;
        endcase
        // break one field
        if (pick < 35) begin
            case ($urandom_range(4))
                0: d = (dim < 31) ? dim + 1 : 0;
                1: m = $urandom_range(1) ? 0 : $urandom_range(15, 13);
                2: h = $urandom_range(31, 24);
                3: mi = $urandom_range(63, 60);
                default: off = $urandom_range(1) ? $urandom_range(2047, MIN_PER_DAY)
                                                 : -int'($urandom_range(2048, MIN_PER_DAY));
            endcase
        end
        return stamp(y, m, d, h, mi, off);
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Cycle watchdog
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Driver: offer requests and toggle result-side ready on the falling edge
    always @(negedge i_clk) begin : drive
        int send_idle;
        int recv_idle;
        if (n_accepted < n_total / 3) begin
            send_idle = 37;
            recv_idle = 46;
        end else if (n_accepted < 2 * n_total / 3) begin
            send_idle = 46;
            recv_idle = 37;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
        if (i_rst_n) begin
            // hold the current request until it is taken
            if (!i_valid || req_taken) begin
                if (stamps_to_send.size() > 0 && $urandom_range(99) >= send_idle) begin
                    cur_req <= stamps_to_send.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Monitor: check results, then predict for each request taken
    always @(posedge i_clk) begin : monitor
        t_dt_result exp_res;
        t_dt_result prd;
        req_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (expected_stamps.size() == 0) begin
                $error("result with no request outstanding");
                n_errors++;
            end else begin
                exp_res = expected_stamps.pop_front();
                if (o_year_out !== exp_res.year_out) begin
                    $error("year_out: expected %0d, got %0d", exp_res.year_out, o_year_out);
                    n_errors++;
                end
                if (o_month_out !== exp_res.month_out) begin
                    $error("month_out: expected %0d, got %0d", exp_res.month_out, o_month_out);
                    n_errors++;
                end
                if (o_day_out !== exp_res.day_out) begin
                    $error("day_out: expected %0d, got %0d", exp_res.day_out, o_day_out);
                    n_errors++;
                end
                if (o_hour_out !== exp_res.hour_out) begin
                    $error("hour_out: expected %0d, got %0d", exp_res.hour_out, o_hour_out);
                    n_errors++;
                end
                if (o_minute_out !== exp_res.minute_out) begin
                    $error("minute_out: expected %0d, got %0d",
                           exp_res.minute_out, o_minute_out);
                    n_errors++;
                end
                if (o_result_valid !== exp_res.result_valid) begin
                    $error("result_valid: expected %0d, got %0d",
                           exp_res.result_valid, o_result_valid);
                    n_errors++;
                end
            end
        end
        if (i_rst_n && i_valid && o_ready) begin
            prd = shift_timestamp(cur_req);
            expected_stamps.push_back(prd);
            n_accepted++;
            if (prd.result_valid)
                n_shifted++;
            else
                n_rejected++;
        end
    end

    // Stimulus and end of run
    initial begin
        i_rst_n    = 1'b0;
        n_total    = 0;

        // year range edges
        stamps_to_send.push_back(stamp(0, 1, 1, 0, 0, -1));
        stamps_to_send.push_back(stamp(MAX_YEAR, 12, 31, 23, 59, 1));
        stamps_to_send.push_back(stamp(MAX_YEAR, 12, 31, 0, 0, MAX_OFFSET));
        stamps_to_send.push_back(stamp(16383, 6, 15, 12, 30, 0));
        stamps_to_send.push_back(stamp(10000, 1, 1, 0, 0, -1));
        // bad month, day, hour, minute
        stamps_to_send.push_back(stamp(2024, 0, 10, 10, 10, 0));
        stamps_to_send.push_back(stamp(2024, 13, 10, 10, 10, 0));
        stamps_to_send.push_back(stamp(2024, 15, 10, 10, 10, 0));
        stamps_to_send.push_back(stamp(2024, 5, 0, 10, 10, 0));
        stamps_to_send.push_back(stamp(2024, 4, 31, 10, 10, 0));
        stamps_to_send.push_back(stamp(2024, 7, 10, 24, 0, 0));
        stamps_to_send.push_back(stamp(2024, 7, 10, 31, 63, 0));
        stamps_to_send.push_back(stamp(2024, 7, 10, 10, 60, 0));
        // leap days
        stamps_to_send.push_back(stamp(1900, 2, 29, 12, 0, 0));
        stamps_to_send.push_back(stamp(2000, 2, 29, 12, 0, 0));
        stamps_to_send.push_back(stamp(0, 2, 29, 23, 59, 1));
        stamps_to_send.push_back(stamp(2024, 2, 28, 23, 0, 60));
        stamps_to_send.push_back(stamp(2023, 2, 28, 23, 30, 30));
        stamps_to_send.push_back(stamp(2024, 3, 1, 0, 0, -1));
        // year rollover and offset bounds
        stamps_to_send.push_back(stamp(2023, 12, 31, 23, 59, 1));
        stamps_to_send.push_back(stamp(2024, 1, 1, 0, 0, -MAX_OFFSET));
        stamps_to_send.push_back(stamp(2024, 1, 1, 0, 0, MIN_PER_DAY));
        stamps_to_send.push_back(stamp(2024, 1, 1, 0, 0, -MIN_PER_DAY));
        stamps_to_send.push_back(stamp(2024, 1, 1, 0, 0, 2047));
        stamps_to_send.push_back(stamp(2024, 1, 1, 0, 0, -2048));
        n_directed = stamps_to_send.size();

        for (int i = 0; i < RANDOM_STAMPS; i++)
            stamps_to_send.push_back(random_stamp());

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        n_total = stamps_to_send.size();
        i_rst_n <= 1'b1;

        // wait for every request to be taken, then for every result
        while (stamps_to_send.size() > 0 || i_valid) @(posedge i_clk);
        while (expected_stamps.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d timestamps (%0d directed) under three stall patterns:",
                 n_accepted, n_directed);
        $display("  %0d shifted to a valid result, %0d rejected, %0d mismatches",
                 n_shifted, n_rejected, n_errors);
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
